/* sv/c8x_pkg.sv */
`default_nettype none
package c8x_pkg;

  localparam int unsigned MemDepthDef   = 4096;
  localparam int unsigned StackDepthDef = 16;
  localparam int unsigned RandDepthDef  = 128;

  localparam logic [11:0] AddrMask  = 12'hFFF;
  localparam logic [11:0] PcReset   = 12'd512;

  localparam int unsigned NumRegs = 16;
  localparam logic [3:0]  RegFlag = 4'd15;

  typedef enum logic [4:0] {
    FN_JP      = 5'd0,
    FN_JP_V0   = 5'd1,
    FN_CALL    = 5'd2,
    FN_SE_IMM  = 5'd3,
    FN_SE_REG  = 5'd4,
    FN_SNE_IMM = 5'd5,
    FN_SNE_REG = 5'd6,
    FN_LD_IMM  = 5'd7,
    FN_LD_REG  = 5'd8,
    FN_LD_I    = 5'd9,
    FN_LD_DT_R = 5'd10,
    FN_SET_DT  = 5'd11,
    FN_SET_ST  = 5'd12,
    FN_ADD_IMM = 5'd13,
    FN_ADD_REG = 5'd14,
    FN_ADD_I   = 5'd15,
    FN_SUB     = 5'd16,
    FN_SUBN    = 5'd17,
    FN_OR      = 5'd18,
    FN_AND     = 5'd19,
    FN_XOR     = 5'd20,
    FN_SHR     = 5'd21,
    FN_SHL     = 5'd22,
    FN_BCD     = 5'd23,
    FN_STORE   = 5'd24,
    FN_LOAD    = 5'd25,
    FN_RAND    = 5'd26,
    FN_SKP     = 5'd27,
    FN_SKNP    = 5'd28,
    FN_MEM_LD  = 5'd29
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_UNSUPP   = 2'd2
  } status_e;

  // Sequencer to memory unit: one byte access per cycle
  typedef struct packed {
    logic        wr_en;
    logic        rd_en;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } mem_req_t;

  // Random byte table: 64 listed bytes, the rest zero
  function automatic logic [7:0] rand_byte(input logic [7:0] idx);
    logic [7:0] r;
    r = 8'd0;
    unique case (idx[5:0])
      6'd0: r = 8'd42;   6'd1: r = 8'd198;  6'd2: r = 8'd124;  6'd3: r = 8'd0;
      6'd4: r = 8'd255;  6'd5: r = 8'd17;   6'd6: r = 8'd233;  6'd7: r = 8'd89;
      6'd8: r = 8'd200;  6'd9: r = 8'd66;   6'd10: r = 8'd70;  6'd11: r = 8'd88;
      6'd12: r = 8'd152; 6'd13: r = 8'd221; 6'd14: r = 8'd31;  6'd15: r = 8'd145;
      6'd16: r = 8'd99;  6'd17: r = 8'd177; 6'd18: r = 8'd234; 6'd19: r = 8'd12;
      6'd20: r = 8'd111; 6'd21: r = 8'd78;  6'd22: r = 8'd245; 6'd23: r = 8'd167;
      6'd24: r = 8'd59;  6'd25: r = 8'd23;  6'd26: r = 8'd29;  6'd27: r = 8'd91;
      6'd28: r = 8'd210; 6'd29: r = 8'd142; 6'd30: r = 8'd47;  6'd31: r = 8'd5;
      6'd32: r = 8'd75;  6'd33: r = 8'd138; 6'd34: r = 8'd180; 6'd35: r = 8'd36;
      6'd36: r = 8'd219; 6'd37: r = 8'd102; 6'd38: r = 8'd189; 6'd39: r = 8'd115;
      6'd40: r = 8'd28;  6'd41: r = 8'd162; 6'd42: r = 8'd250; 6'd43: r = 8'd200;
      6'd44: r = 8'd83;  6'd45: r = 8'd155; 6'd46: r = 8'd63;  6'd47: r = 8'd229;
      6'd48: r = 8'd131; 6'd49: r = 8'd44;  6'd50: r = 8'd16;  6'd51: r = 8'd173;
      6'd52: r = 8'd96;  6'd53: r = 8'd241; 6'd54: r = 8'd19;  6'd55: r = 8'd137;
      6'd56: r = 8'd72;  6'd57: r = 8'd150; 6'd58: r = 8'd254; 6'd59: r = 8'd107;
      6'd60: r = 8'd33;  6'd61: r = 8'd184; 6'd62: r = 8'd121; 6'd63: r = 8'd205;
      default: r = 8'd0;
    endcase
    if (idx[7:6] != 2'd0) r = 8'd0;
    return r;
  endfunction

  // Binary to BCD for one byte: shift-and-add, eight narrow steps
  function automatic logic [11:0] to_bcd(input logic [7:0] v);
    logic [11:0] b;
    b = 12'd0;
    for (int i = 7; i >= 0; i--) begin
      if (b[3:0] >= 4'd5) b[3:0] = b[3:0] + 4'd3;
      if (b[7:4] >= 4'd5) b[7:4] = b[7:4] + 4'd3;
      b = {b[10:0], v[i]};
    end
    return b;
  endfunction

endpackage
`default_nettype wire

/* sv/c8x_mem.sv */
`default_nettype none
module c8x_mem #(
  parameter int unsigned MemDepth = c8x_pkg::MemDepthDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire c8x_pkg::mem_req_t req_i,
  output logic [7:0]             rdata_o,
  output logic                   clr_busy_o
);
  import c8x_pkg::*;

  localparam int unsigned AW = $clog2(MemDepth);

  logic [7:0]    mem_q [MemDepth];
  logic [AW:0]   clr_cnt_q, clr_cnt_d;

  // Sweep zeros through the memory after reset
  assign clr_busy_o = (clr_cnt_q != AW'(0) + (AW+1)'(MemDepth)) ;
  assign clr_cnt_d  = clr_cnt_q + (AW+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clr_busy_o) begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Single port: write or registered read
  always_ff @(posedge clk_i) begin
    if (clr_busy_o) begin
      mem_q[clr_cnt_q[AW-1:0]] <= 8'd0;
    end else if (req_i.wr_en) begin
      mem_q[req_i.addr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_o <= mem_q[req_i.addr[AW-1:0]];
    end
  end

endmodule
`default_nettype wire

/* sv/c8x_regs.sv */
`default_nettype none
module c8x_regs (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [3:0] raddr_a_i,
  input  wire logic [3:0] raddr_b_i,
  output logic [7:0]      rdata_a_o,
  output logic [7:0]      rdata_b_o,
  input  wire logic       we_i,
  input  wire logic [3:0] waddr_i,
  input  wire logic [7:0] wdata_i
);
  import c8x_pkg::*;

  logic [7:0] rf_q [NumRegs];

  // Two read ports, one write port; reset clears all registers
  assign rdata_a_o = rf_q[raddr_a_i];
  assign rdata_b_o = rf_q[raddr_b_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) rf_q[i] <= 8'd0;
    end else if (we_i) begin
      rf_q[waddr_i] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

/* sv/chip8_execute_unit_core.sv */
`default_nettype none
// Sequence: input transfer, S_EXEC, then S_OUT for most ops; shifts pass through S_BCD
// to write VF, BCD writes three digits in S_BCD, block store and block load step through
// S_BLK one memory byte per cycle. One item in flight; the next transfer can be taken in
// the cycle after the result transfer, once the unit is back in S_IDLE.
// Reset: asynchronous, active low; memory is zeroed by a sweep over all MemDepth
// addresses (4096 by default) during which no item is accepted.
module chip8_execute_unit_core #(
  parameter int unsigned MemDepth   = c8x_pkg::MemDepthDef,
  parameter int unsigned StackDepth = c8x_pkg::StackDepthDef,
  parameter int unsigned RandDepth  = c8x_pkg::RandDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // func[4:0], reg_x[8:5], reg_y[12:9], imm_byte[20:13], target_address[32:21],
  // key_down[33], zero fill [39:34]
  input  wire logic [39:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // pc_out[11:0], index_out[23:12], reg_value[31:24], delay_out[39:32],
  // sound_out[47:40], status[49:48], zero fill [55:50]
  output logic [55:0]      m_axis_tdata
);
  import c8x_pkg::*;

  localparam int unsigned SPW = $clog2(StackDepth + 1);
  localparam int unsigned SIW = $clog2(StackDepth);
  localparam int unsigned RPW = $clog2(RandDepth);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_BLK  = 3'd2;
  localparam logic [2:0] S_BCD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [4:0]  fn_q;
  logic [3:0]  x_q, y_q;
  logic [7:0]  imm_q;
  logic [11:0] addr_q;
  logic        key_q;

  logic [11:0] pc_q, pc_d;
  logic [11:0] idx_q, idx_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [11:0] stk_q [StackDepth];
  logic [7:0]  dt_q, dt_d, st_q, st_d;
  logic [RPW-1:0] rp_q, rp_d;
  logic [1:0]  status_q, status_d;
  logic [4:0]  k_q, k_d;
  logic [11:0] bcd_q;
  logic        flag_q;

  logic [3:0]  rf_ra, rf_wa;
  logic [7:0]  vx, vy, rf_wd;
  logic        rf_we;
  logic [7:0]  mem_rdata;
  logic        clr_busy;
  mem_req_t    mreq;
  logic [7:0]  vx_res;
  logic        stk_we;

  assign s_axis_tready = (state_q == S_IDLE) && !clr_busy;
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {6'd0, status_q, st_q, dt_q, vx, idx_q, pc_q};

  // Capture the item; also register the BCD of Vx and write the stack slot on a call
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      fn_q   <= s_axis_tdata[4:0];
      x_q    <= s_axis_tdata[8:5];
      y_q    <= s_axis_tdata[12:9];
      imm_q  <= s_axis_tdata[20:13];
      addr_q <= s_axis_tdata[32:21];
      key_q  <= s_axis_tdata[33];
    end
    if (state_q == S_EXEC) bcd_q <= to_bcd(vx);
    if (stk_we) stk_q[sp_q[SIW-1:0]] <= pc_q;
  end

  c8x_regs u_regs (
    .clk_i, .rst_ni,
    .raddr_a_i(rf_ra), .raddr_b_i(y_q),
    .rdata_a_o(vx), .rdata_b_o(vy),
    .we_i(rf_we), .waddr_i(rf_wa), .wdata_i(rf_wd)
  );

  c8x_mem #(.MemDepth(MemDepth)) u_mem (
    .clk_i, .rst_ni, .req_i(mreq), .rdata_o(mem_rdata), .clr_busy_o(clr_busy)
  );

  // Combinational ALU result for ops that write Vx
  always_comb begin
    vx_res = vx;
    unique case (fn_q)
      FN_LD_IMM:  vx_res = imm_q;
      FN_LD_REG:  vx_res = vy;
      FN_LD_DT_R: vx_res = dt_q;
      FN_ADD_IMM: vx_res = vx + imm_q;
      FN_ADD_REG: vx_res = vx + vy;
      FN_SUB:     vx_res = vx - vy;
      FN_SUBN:    vx_res = vy - vx;
      FN_OR:      vx_res = vx | vy;
      FN_AND:     vx_res = vx & vy;
      FN_XOR:     vx_res = vx ^ vy;
      FN_SHR:     vx_res = {1'b0, vx[7:1]};
      FN_SHL:     vx_res = {vx[6:0], 1'b0};
      FN_RAND:    vx_res = rand_byte(8'(rp_q)) & imm_q;
      default:    vx_res = vx;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    pc_d     = pc_q;
    idx_d    = idx_q;
    sp_d     = sp_q;
    dt_d     = dt_q;
    st_d     = st_q;
    rp_d     = rp_q;
    status_d = status_q;
    k_d      = k_q;
    rf_ra    = x_q;
    rf_we    = 1'b0;
    rf_wa    = x_q;
    rf_wd    = vx_res;
    stk_we   = 1'b0;
    mreq     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) state_d = S_EXEC;
      end
      S_EXEC: begin
        status_d = ST_OK;
        state_d  = S_OUT;
        k_d      = 5'd0;
        if (fn_q > FN_MEM_LD) begin
          status_d = ST_UNSUPP;
        end else begin
          unique case (fn_q)
            FN_JP:      pc_d = addr_q;
            FN_JP_V0: begin
              // Offset always comes from V0
              rf_ra = 4'd0;
              pc_d  = addr_q + 12'(vx);
            end
            FN_CALL: begin
              if (sp_q < SPW'(StackDepth)) begin
                stk_we = 1'b1;
                sp_d   = sp_q + SPW'(1);
                pc_d   = addr_q;
              end else begin
                status_d = ST_OVERFLOW;
              end
            end
            FN_SE_IMM:  if (vx == imm_q) pc_d = pc_q + 12'd2;
            FN_SE_REG:  if (vx == vy)    pc_d = pc_q + 12'd2;
            FN_SNE_IMM: if (vx != imm_q) pc_d = pc_q + 12'd2;
            FN_SNE_REG: if (vx != vy)    pc_d = pc_q + 12'd2;
            FN_SKP:     if (key_q)       pc_d = pc_q + 12'd2;
            FN_SKNP:    if (!key_q)      pc_d = pc_q + 12'd2;
            FN_LD_I:    idx_d = addr_q;
            FN_ADD_I:   idx_d = idx_q + 12'(vx);
            FN_SET_DT:  dt_d = vx;
            FN_SET_ST:  st_d = vx;
            FN_SHR, FN_SHL: begin
              rf_we   = 1'b1;
              state_d = S_BCD;
              k_d     = 5'd3;
            end
            FN_RAND: begin
              rf_we = 1'b1;
              rp_d  = (rp_q == RPW'(RandDepth - 1)) ? '0 : rp_q + RPW'(1);
            end
            FN_LD_IMM, FN_LD_REG, FN_LD_DT_R, FN_ADD_IMM, FN_ADD_REG,
            FN_SUB, FN_SUBN, FN_OR, FN_AND, FN_XOR: rf_we = 1'b1;
            FN_BCD:     state_d = S_BCD;
            FN_STORE, FN_LOAD: state_d = S_BLK;
            FN_MEM_LD: begin
              mreq.wr_en = 1'b1;
              mreq.addr  = 16'(addr_q);
              mreq.wdata = imm_q;
            end
            default: ;
          endcase
        end
      end
      S_BCD: begin
        // Shift flag into VF (k=3), or write one BCD digit per cycle
        if (k_q == 5'd3) begin
          rf_we   = 1'b1;
          rf_wa   = RegFlag;
          rf_wd   = {7'd0, flag_q};
          state_d = S_OUT;
        end else begin
          mreq.wr_en = 1'b1;
          mreq.addr  = 16'(idx_q) + 16'(k_q);
          unique case (k_q[1:0])
            2'd0:    mreq.wdata = {4'd0, bcd_q[11:8]};
            2'd1:    mreq.wdata = {4'd0, bcd_q[7:4]};
            default: mreq.wdata = {4'd0, bcd_q[3:0]};
          endcase
          k_d = k_q + 5'd1;
          if (k_q == 5'd2) state_d = S_OUT;
        end
      end
      S_BLK: begin
        // One byte per cycle; loads write back in the cycle after the read
        rf_ra = k_q[3:0];
        if (fn_q == FN_STORE) begin
          if (k_q <= {1'b0, x_q}) begin
            mreq.wr_en = 1'b1;
            mreq.addr  = 16'(idx_q) + 16'(k_q);
            mreq.wdata = vx;
            k_d = k_q + 5'd1;
          end else begin
            state_d = S_OUT;
          end
        end else begin
          if (k_q <= {1'b0, x_q}) begin
            mreq.rd_en = 1'b1;
            mreq.addr  = 16'(idx_q) + 16'(k_q);
          end
          if (k_q != 5'd0) begin
            rf_we = 1'b1;
            rf_wa = 4'(k_q - 5'd1);
            rf_wd = mem_rdata;
          end
          k_d = k_q + 5'd1;
          if (k_q == {1'b0, x_q} + 5'd1) state_d = S_OUT;
        end
      end
      S_OUT: begin
        rf_ra = x_q;
        if (m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Saved shift-out bit for the flag write
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) flag_q <= (fn_q == FN_SHR) ? vx[0] : vx[7];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pc_q     <= PcReset;
      idx_q    <= 12'd0;
      sp_q     <= '0;
      dt_q     <= 8'd0;
      st_q     <= 8'd0;
      rp_q     <= '0;
      status_q <= ST_OK;
      k_q      <= 5'd0;
    end else begin
      state_q  <= state_d;
      pc_q     <= pc_d;
      idx_q    <= idx_d;
      sp_q     <= sp_d;
      dt_q     <= dt_d;
      st_q     <= st_d;
      rp_q     <= rp_d;
      status_q <= status_d;
      k_q      <= k_d;
    end
  end

endmodule
`default_nettype wire

/* sv/chip8_execute_unit_core_chk.sv */
`default_nettype none
module chip8_execute_unit_core_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [55:0] m_axis_tdata
);
  // No new transfer in while a result waits
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken during output");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Status is never the reserved code
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[49:48] != 2'd3) else $error("bad status");

  // An accepted item gives no result in the cycle after it is taken
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid) else $error("early result");
endmodule

bind chip8_execute_unit_core chip8_execute_unit_core_chk u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire
